[rtl/pptok_pkg.sv]
// Shared types and constants for the property path tokenizer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package pptok_pkg;

  // Field widths
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 30;
  localparam int DCOUNT_W = 4;

  // Default longest index, in decimal digits
  localparam int MAX_INDEX_DIGITS_DEF = 9;

  // Significant characters
  localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CHAR_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_NAME    = 3'd1,
    MODE_BRACKET = 3'd2,
    MODE_AFTER   = 3'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_NAME_END = 2'd1,
    KIND_INDEX    = 2'd2,
    KIND_STATUS   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_UNCLOSED   = 3'd1,
    STAT_BAD_INDEX  = 3'd2,
    STAT_EMPTY_STEP = 3'd3,
    STAT_EMPTY_PATH = 3'd4
  } status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              no_char;
    logic              path_end;
  } path_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  name_byte;
    logic [INDEX_W-1:0] index_value;
    status_t            status;
  } token_t;

  // Up to three tokens caused by one item, packed from slot 0 upward
  typedef struct packed {
    token_t [2:0] slot;
    logic   [1:0] count;
  } token_group_t;

  typedef struct packed {
    mode_t               mode;
    status_t             err;
    logic [INDEX_W-1:0]  acc;
    logic [DCOUNT_W-1:0] dcount;
    logic                bad;
    logic                any_seg;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    mode:    MODE_START,
    err:     STAT_OK,
    acc:     '0,
    dcount:  '0,
    bad:     1'b0,
    any_seg: 1'b0
  };

endpackage

[rtl/pptok_in_if.sv]
// Path byte channel: valid/ready handshake with one path item as payload.
// Depends on pptok_pkg.
`timescale 1ns / 1ps

interface pptok_in_if import pptok_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              no_char;
  logic              path_end;

  modport source (output valid, output char_code, output no_char, output path_end,
                  input ready);
  modport sink   (input valid, input char_code, input no_char, input path_end,
                  output ready);
endinterface

[rtl/pptok_out_if.sv]
// Token channel: valid/ready handshake with one token as payload.
// Depends on pptok_pkg.
`timescale 1ns / 1ps

interface pptok_out_if import pptok_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [CHAR_W-1:0]  name_byte;
  logic [INDEX_W-1:0] index_value;
  status_t            status;
  logic               run_last;

  modport source (output valid, output kind, output name_byte, output index_value,
                  output status, output run_last, input ready);
  modport sink   (input valid, input kind, input name_byte, input index_value,
                  input status, input run_last, output ready);
endinterface

[rtl/property_path_tokenizer_top.sv]
// Property path tokenizer top level: input register, parser step, token group register.
// Depends on pptok_pkg, pptok_in_if, pptok_out_if and pptok_step.
//
//   channel     dir  payload                                          handshake
//   path_chan   in   char_code[7:0], no_char, path_end                valid/ready
//   token_chan  out  kind[1:0], name_byte[7:0], index_value[29:0],    valid/ready
//                    status[2:0], run_last
//
// An item is registered on acceptance and parsed from there; its tokens (zero to three)
// load the group register when free; tokens leave one per cycle while ready is high.
// Items causing at most one token flow at one per cycle while ready is high; an item
// causing more holds the next back until its last token leaves the single output port.
// Reset clears the parse state, the input register and the group register.
// A stalled token output holds the group register; the input register keeps accepting
// while it is empty or its item moves into the group register in the same cycle.
`timescale 1ns / 1ps

module property_path_tokenizer_top import pptok_pkg::*; #(
  parameter int MAX_INDEX_DIGITS = MAX_INDEX_DIGITS_DEF
) (
  input logic         clk,
  input logic         rst,
  pptok_in_if.sink    path_chan,
  pptok_out_if.source token_chan
);

  logic         s1_valid;
  path_item_t   s1_item;
  parse_state_t st;
  parse_state_t st_next;
  token_group_t grp;
  token_group_t grp_next;
  logic         grp_free;
  logic         s1_adv;
  logic         pop;

  // Parser step
  pptok_step #(
    .MAX_INDEX_DIGITS(MAX_INDEX_DIGITS)
  ) u_step (
    .cur  (st),
    .item (s1_item),
    .nxt  (st_next),
    .group(grp_next)
  );

  // Handshake control
  assign pop             = token_chan.valid && token_chan.ready;
  assign grp_free        = (grp.count == 2'd0) || (grp.count == 2'd1 && token_chan.ready);
  assign s1_adv          = s1_valid && grp_free;
  assign path_chan.ready = !s1_valid || grp_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (path_chan.ready) begin
      s1_valid <= path_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (path_chan.ready && path_chan.valid) begin
      s1_item <= '{char_code: path_chan.char_code, no_char: path_chan.no_char,
                   path_end: path_chan.path_end};
    end
  end

  // Parse state: advance when the registered item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PARSE_RESET;
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  // Token group register: load a new group, or shift out one token
  always_ff @(posedge clk) begin
    if (rst) begin
      grp.count <= 2'd0;
    end else if (s1_adv) begin
      grp <= grp_next;
    end else if (pop) begin
      grp.count   <= grp.count - 2'd1;
      grp.slot[0] <= grp.slot[1];
      grp.slot[1] <= grp.slot[2];
    end
  end

  // Output drive
  assign token_chan.valid       = (grp.count != 2'd0);
  assign token_chan.kind        = grp.slot[0].kind;
  assign token_chan.name_byte   = grp.slot[0].name_byte;
  assign token_chan.index_value = grp.slot[0].index_value;
  assign token_chan.status      = grp.slot[0].status;
  assign token_chan.run_last    = (grp.count == 2'd1);

  // Checks
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    token_chan.valid && token_chan.kind == KIND_STATUS |-> token_chan.run_last)
    else $error("status token not marked last");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    token_chan.valid |-> token_chan.status <= STAT_EMPTY_PATH)
    else $error("status code out of range");

  a_index_only_on_index: assert property (@(posedge clk) disable iff (rst)
    token_chan.valid && token_chan.kind != KIND_INDEX |-> token_chan.index_value == '0)
    else $error("index value on a non-index token");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    st.dcount <= DCOUNT_W'(MAX_INDEX_DIGITS))
    else $error("digit count past limit");

endmodule

[rtl/pptok_step.sv]
// Per-item parser step: next parse state and the tokens one item causes.
// Purely combinational. Depends on pptok_pkg.
`timescale 1ns / 1ps

module pptok_step import pptok_pkg::*; #(
  parameter int MAX_INDEX_DIGITS = MAX_INDEX_DIGITS_DEF
) (
  input  parse_state_t cur,
  input  path_item_t   item,
  output parse_state_t nxt,
  output token_group_t group
);

  parse_state_t       mid;
  token_t             tok_byte, tok_end, tok_stat;
  logic               byte_v, end_v;
  status_t            fin_err;
  logic               fin_any;
  logic [CHAR_W-1:0]  ch;
  logic [3:0]         digit;
  logic [INDEX_W-1:0] acc_x10;
  logic [1:0]         n_tok;

  assign ch      = item.char_code;
  assign digit   = ch[3:0];
  assign acc_x10 = {cur.acc[INDEX_W-4:0], 3'b000} + {cur.acc[INDEX_W-2:0], 1'b0}
                 + INDEX_W'(digit);

  // Byte phase: act on the character unless an error is already latched
  always_comb begin
    mid      = cur;
    byte_v   = 1'b0;
    tok_byte = '0;
    if (!item.no_char && cur.err == STAT_OK) begin
      case (cur.mode)
        MODE_NAME: begin
          byte_v = 1'b1;
          if (ch == CHAR_DOT || ch == CHAR_LBRACK) begin
            tok_byte.kind = KIND_NAME_END;
            mid.any_seg   = 1'b1;
            if (ch == CHAR_DOT) begin
              mid.mode = MODE_START;
            end else begin
              mid.mode   = MODE_BRACKET;
              mid.acc    = '0;
              mid.dcount = '0;
              mid.bad    = 1'b0;
            end
          end else begin
            tok_byte.kind      = KIND_BYTE;
            tok_byte.name_byte = ch;
          end
        end
        MODE_BRACKET: begin
          if (ch == CHAR_RBRACK) begin
            if (cur.bad || cur.dcount == '0) begin
              mid.err = STAT_BAD_INDEX;
            end else begin
              byte_v               = 1'b1;
              tok_byte.kind        = KIND_INDEX;
              tok_byte.index_value = cur.acc;
              mid.any_seg          = 1'b1;
              mid.mode             = MODE_AFTER;
            end
          end else if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
            if (cur.dcount < DCOUNT_W'(MAX_INDEX_DIGITS)) begin
              mid.acc    = acc_x10;
              mid.dcount = cur.dcount + 1'b1;
            end else begin
              mid.bad = 1'b1;
            end
          end else begin
            mid.bad = 1'b1;
          end
        end
        default: begin
          // Segment start, or just after a closing bracket
          if (ch == CHAR_DOT) begin
            if (cur.mode == MODE_AFTER) begin
              mid.mode = MODE_START;
            end else begin
              mid.err = STAT_EMPTY_STEP;
            end
          end else if (ch == CHAR_LBRACK) begin
            mid.mode   = MODE_BRACKET;
            mid.acc    = '0;
            mid.dcount = '0;
            mid.bad    = 1'b0;
          end else begin
            byte_v             = 1'b1;
            tok_byte.kind      = KIND_BYTE;
            tok_byte.name_byte = ch;
            mid.mode           = MODE_NAME;
          end
        end
      endcase
    end
  end

  // End phase: close an open name, settle the final status, return to reset
  always_comb begin
    end_v    = 1'b0;
    tok_end  = '0;
    tok_stat = '0;
    fin_err  = mid.err;
    fin_any  = mid.any_seg;
    nxt      = mid;
    if (item.path_end) begin
      if (fin_err == STAT_OK) begin
        if (mid.mode == MODE_NAME) begin
          end_v        = 1'b1;
          tok_end.kind = KIND_NAME_END;
          fin_any      = 1'b1;
        end else if (mid.mode == MODE_BRACKET) begin
          fin_err = STAT_UNCLOSED;
        end
      end
      if (fin_err == STAT_OK && !fin_any) begin
        fin_err = STAT_EMPTY_PATH;
      end
      tok_stat.kind   = KIND_STATUS;
      tok_stat.status = fin_err;
      nxt             = PARSE_RESET;
    end
  end

  // Pack the valid tokens from slot 0 upward
  always_comb begin
    n_tok = 2'(byte_v) + 2'(end_v) + 2'(item.path_end);
    group.count   = n_tok;
    group.slot[2] = tok_stat;
    group.slot[1] = (byte_v && end_v) ? tok_end : tok_stat;
    group.slot[0] = byte_v ? tok_byte : (end_v ? tok_end : tok_stat);
  end

endmodule
